>>> rtl/core/fdsu_pkg.sv
package fdsu_pkg;

    localparam int DEF_STACK_DEPTH = 64;
    localparam int WORD_W          = 32;

    // operation codes
    localparam logic [3:0] FN_PUSH  = 4'd0;
    localparam logic [3:0] FN_ADD   = 4'd1;
    localparam logic [3:0] FN_SUB   = 4'd2;
    localparam logic [3:0] FN_MUL   = 4'd3;
    localparam logic [3:0] FN_DIV   = 4'd4;
    localparam logic [3:0] FN_MOD   = 4'd5;
    localparam logic [3:0] FN_DOT   = 4'd6;
    localparam logic [3:0] FN_PICK  = 4'd7;
    localparam logic [3:0] FN_ROLL  = 4'd8;
    localparam logic [3:0] FN_CLEAR = 4'd9;

    // status codes
    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_EMPTY    = 3'd1;
    localparam logic [2:0] STS_DIV0     = 3'd2;
    localparam logic [2:0] STS_NEGIDX   = 3'd3;
    localparam logic [2:0] STS_OVERFLOW = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT,
        S_OPER,
        S_DIV,
        S_WRB,
        S_ROLL,
        S_ROLLW,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [3:0]         func;
        logic signed [31:0] operand;
    } in_t;

    typedef struct packed {
        logic               printed;
        logic signed [31:0] printed_value;
        logic [2:0]         status;
        logic [6:0]         depth;
        logic signed [31:0] top_value;
    } out_t;

endpackage

>>> rtl/core/fdsu_mem.sv
module fdsu_mem #(
    parameter int DEPTH = fdsu_pkg::DEF_STACK_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [fdsu_pkg::WORD_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [fdsu_pkg::WORD_W-1:0] rd_data
);
    import fdsu_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/fdsu_div.sv
module fdsu_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [fdsu_pkg::WORD_W-1:0] dividend,
    input  logic [fdsu_pkg::WORD_W-1:0] divisor,
    output logic                        done,
    output logic [fdsu_pkg::WORD_W-1:0] quotient,
    output logic [fdsu_pkg::WORD_W-1:0] remainder
);
    import fdsu_pkg::*;

    localparam int CNT_W = $clog2(WORD_W + 1);

    logic [WORD_W-1:0] q_reg, q_next;
    logic [WORD_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WORD_W:0]   trial;

    // one restoring step per cycle
    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[WORD_W-1]};
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = CNT_W'(WORD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                r_next = WORD_W'(trial - {1'b0, divisor});
                q_next = {q_reg[WORD_W-2:0], 1'b1};
            end else begin
                r_next = trial[WORD_W-1:0];
                q_next = {q_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

>>> rtl/core/forth_data_stack_unit.sv
// Forth data stack: one request at a time, one result per request. The stack
// lives in a single RAM (one write, one registered read port); the top item
// is also cached in a register. Push, clear and every error or ignored code
// finish without a RAM read; dot and arithmetic with two or more items, and
// pick with an index inside the stack, read the RAM first. Arithmetic then
// computes and writes the result back; div/mod use the 32-step radix-2
// divider. Roll moves one entry at a time through the RAM port, a read and
// then a write per entry; past the depth it shifts every entry down and puts
// zero on top. The sequencer returns to idle as the result is loaded, and a
// result still waiting in the output register holds the sequencer in its
// final state. Reset needs no clearing pass: entries above the count are
// never read. The depth output carries the low 7 bits of the count.
module forth_data_stack_unit #(
    parameter int STACK_DEPTH = fdsu_pkg::DEF_STACK_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  fdsu_pkg::in_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output fdsu_pkg::out_t m_data
);
    import fdsu_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    state_t              state_reg, state_next;
    logic [3:0]          func_reg, func_next;
    logic [WORD_W-1:0]   opnd_reg, opnd_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [WORD_W-1:0]   top_reg, top_next;
    logic [WORD_W-1:0]   b_reg, b_next;
    logic [WORD_W-1:0]   r_reg, r_next;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic                printed_reg, printed_next;
    logic [WORD_W-1:0]   pval_reg, pval_next;
    logic [2:0]          status_reg, status_next;
    logic                m_valid_reg, m_valid_next;
    out_t                m_data_reg, m_data_next;

    logic                wr_en, rd_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [WORD_W-1:0]   wr_data, rd_data;

    logic                div_start, div_done;
    logic [WORD_W-1:0]   div_q, div_r, ua, ub;

    logic                full, ge2, idx_in, neg;
    logic [WORD_W-1:0]   cnt32, pick_idx;
    logic [CW-1:0]       cnt_m1, cnt_m2;

    function automatic logic [WORD_W-1:0] magnitude(input logic [WORD_W-1:0] v);
        magnitude = v[WORD_W-1] ? (WORD_W'(0) - v) : v;
    endfunction

    fdsu_mem #(.DEPTH(STACK_DEPTH), .AW(AW)) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign ua = magnitude(top_reg);
    assign ub = magnitude(b_reg);

    fdsu_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (ub),
        .divisor   (ua),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // stack geometry
    assign full     = (count_reg == CW'(STACK_DEPTH));
    assign ge2      = (count_reg >= CW'(2));
    assign neg      = opnd_reg[WORD_W-1];
    assign cnt32    = WORD_W'(count_reg);
    assign idx_in   = (opnd_reg < cnt32);
    assign pick_idx = cnt32 - WORD_W'(1) - opnd_reg;
    assign cnt_m1   = count_reg - CW'(1);
    assign cnt_m2   = count_reg - CW'(2);

    assign s_ready = (state_reg == S_IDLE);

    // sequencer: next state, stack update and RAM control
    always_comb begin
        state_next   = state_reg;
        func_next    = func_reg;
        opnd_next    = opnd_reg;
        count_next   = count_reg;
        top_next     = top_reg;
        b_next       = b_reg;
        r_next       = r_reg;
        ptr_next     = ptr_reg;
        printed_next = printed_reg;
        pval_next    = pval_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        wr_addr      = AW'(count_reg);
        wr_data      = opnd_reg;
        rd_en        = 1'b0;
        rd_addr      = AW'(cnt_m2);
        div_start    = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    func_next    = s_data.func;
                    opnd_next    = s_data.operand;
                    printed_next = 1'b0;
                    pval_next    = '0;
                    status_next  = STS_OK;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_DONE;
                case (func_reg) inside
                    FN_PUSH: begin
                        if (full) begin
                            status_next = STS_OVERFLOW;
                        end else begin
                            wr_en      = 1'b1;
                            top_next   = opnd_reg;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MOD: begin
                        if (count_reg == '0) begin
                            status_next = STS_EMPTY;
                        end else if ((func_reg == FN_DIV || func_reg == FN_MOD)
                                     && top_reg == '0) begin
                            count_next  = '0;
                            top_next    = '0;
                            status_next = STS_DIV0;
                        end else if (ge2) begin
                            rd_en      = 1'b1;
                            state_next = S_WAIT;
                        end else begin
                            b_next     = '0;
                            state_next = S_OPER;
                        end
                    end
                    FN_DOT: begin
                        if (count_reg == '0) begin
                            status_next = STS_EMPTY;
                        end else begin
                            printed_next = 1'b1;
                            pval_next    = top_reg;
                            if (ge2) begin
                                rd_en      = 1'b1;
                                state_next = S_WAIT;
                            end else begin
                                count_next = '0;
                                top_next   = '0;
                            end
                        end
                    end
                    FN_PICK: begin
                        if (neg) begin
                            count_next  = '0;
                            top_next    = '0;
                            status_next = STS_NEGIDX;
                        end else if (full) begin
                            status_next = STS_OVERFLOW;
                        end else if (idx_in) begin
                            rd_en      = 1'b1;
                            rd_addr    = AW'(pick_idx);
                            state_next = S_WAIT;
                        end else begin
                            wr_en      = 1'b1;
                            wr_data    = '0;
                            top_next   = '0;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    FN_ROLL: begin
                        if (neg) begin
                            count_next  = '0;
                            top_next    = '0;
                            status_next = STS_NEGIDX;
                        end else if (count_reg != '0 && opnd_reg != '0) begin
                            if (idx_in) begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(pick_idx);
                                ptr_next   = CW'(pick_idx) + CW'(1);
                                state_next = S_WAIT;
                            end else begin
                                b_next     = '0;
                                ptr_next   = CW'(1);
                                state_next = S_ROLL;
                            end
                        end
                    end
                    FN_CLEAR: begin
                        count_next = '0;
                        top_next   = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_WAIT: begin
                state_next = S_DONE;
                case (func_reg)
                    FN_DOT: begin
                        top_next   = rd_data;
                        count_next = cnt_m1;
                    end
                    FN_PICK: begin
                        wr_en      = 1'b1;
                        wr_data    = rd_data;
                        top_next   = rd_data;
                        count_next = count_reg + CW'(1);
                    end
                    FN_ROLL: begin
                        b_next     = rd_data;
                        state_next = S_ROLL;
                    end
                    default: begin
                        b_next     = rd_data;
                        state_next = S_OPER;
                    end
                endcase
            end
            S_OPER: begin
                state_next = S_WRB;
                case (func_reg)
                    FN_ADD: r_next = b_reg + top_reg;
                    FN_SUB: r_next = b_reg - top_reg;
                    FN_MUL: r_next = WORD_W'(b_reg * top_reg);
                    default: begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    if (func_reg == FN_DIV) begin
                        r_next = (top_reg[WORD_W-1] ^ b_reg[WORD_W-1]) ?
                                 (WORD_W'(0) - div_q) : div_q;
                    end else begin
                        r_next = b_reg[WORD_W-1] ? (WORD_W'(0) - div_r) : div_r;
                    end
                    state_next = S_WRB;
                end
            end
            S_WRB: begin
                // drop the consumed second operand, if any, and write the result on top
                wr_en    = 1'b1;
                wr_data  = r_reg;
                top_next = r_reg;
                if (ge2) begin
                    count_next = cnt_m1;
                    wr_addr    = AW'(cnt_m2);
                end else begin
                    wr_addr = AW'(cnt_m1);
                end
                state_next = S_DONE;
            end
            S_ROLL: begin
                if (ptr_reg < count_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(ptr_reg);
                    state_next = S_ROLLW;
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = AW'(cnt_m1);
                    wr_data    = b_reg;
                    top_next   = b_reg;
                    state_next = S_DONE;
                end
            end
            S_ROLLW: begin
                // shift one entry down
                wr_en      = 1'b1;
                wr_addr    = AW'(ptr_reg - CW'(1));
                wr_data    = rd_data;
                ptr_next   = ptr_reg + CW'(1);
                state_next = S_ROLL;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.printed       = printed_reg;
                    m_data_next.printed_value = pval_reg;
                    m_data_next.status        = status_reg;
                    m_data_next.depth         = 7'(count_reg);
                    m_data_next.top_value     = top_reg;
                    m_valid_next              = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            top_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            top_reg     <= top_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        func_reg    <= func_next;
        opnd_reg    <= opnd_next;
        b_reg       <= b_next;
        r_reg       <= r_next;
        ptr_reg     <= ptr_next;
        printed_reg <= printed_next;
        pval_reg    <= pval_next;
        status_reg  <= status_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_empty_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (top_reg == '0))
        else $error("top cache not zero on empty stack");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_EXEC))
        else $error("request not taken into execution");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result issued outside completion");
`endif

endmodule

>>> tb/tb_forth_data_stack_unit.sv
module tb_forth_data_stack_unit;
    import fdsu_pkg::*;

    localparam int DEPTH = DEF_STACK_DEPTH;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    forth_data_stack_unit #(.STACK_DEPTH(DEPTH)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    // predictor state: index 0 is the bottom
    logic [31:0] stk_mem [DEPTH];
    int unsigned stk_cnt;
    out_t        pending_results [$];
    int          mismatches = 0;
    bit          rx_calm = 1'b0;
    bit          tx_calm = 1'b0;
    int          rx_hold = 0;

    // wipe the predicted stack
    function automatic void stk_clear();
        for (int i = 0; i < DEPTH; i++) stk_mem[i] = '0;
        stk_cnt = 0;
    endfunction

    function automatic logic [31:0] abs32(logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    // compute the result of one request and advance the predicted stack
    function automatic out_t stack_predict(in_t req);
        out_t r;
        logic [31:0] a, b, q, v, saved, opnd;
        int unsigned k;
        r = '0;
        opnd = req.operand;
        case (req.func) inside
            FN_PUSH: begin
                if (stk_cnt >= DEPTH) r.status = STS_OVERFLOW;
                else begin
                    stk_mem[stk_cnt] = opnd;
                    stk_cnt++;
                end
            end
            FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MOD: begin
                if (stk_cnt == 0) r.status = STS_EMPTY;
                else begin
                    a = stk_mem[stk_cnt-1];
                    b = (stk_cnt >= 2) ? stk_mem[stk_cnt-2] : 32'd0;
                    if ((req.func == FN_DIV || req.func == FN_MOD) && a == 0) begin
                        stk_clear();
                        r.status = STS_DIV0;
                    end else begin
                        case (req.func)
                            FN_ADD: v = b + a;
                            FN_SUB: v = b - a;
                            FN_MUL: v = b * a;
                            FN_DIV: begin
                                q = abs32(b) / abs32(a);
                                v = (a[31] ^ b[31]) ? (32'd0 - q) : q;
                            end
                            default: begin
                                q = abs32(b) % abs32(a);
                                v = b[31] ? (32'd0 - q) : q;
                            end
                        endcase
                        if (stk_cnt >= 2) stk_cnt--;
                        stk_mem[stk_cnt-1] = v;
                    end
                end
            end
            FN_DOT: begin
                if (stk_cnt == 0) r.status = STS_EMPTY;
                else begin
                    r.printed = 1'b1;
                    r.printed_value = stk_mem[stk_cnt-1];
                    stk_cnt--;
                end
            end
            FN_PICK: begin
                if (opnd[31]) begin
                    stk_clear();
                    r.status = STS_NEGIDX;
                end else if (stk_cnt >= DEPTH) r.status = STS_OVERFLOW;
                else begin
                    v = (opnd < stk_cnt) ? stk_mem[stk_cnt-1-opnd] : 32'd0;
                    stk_mem[stk_cnt] = v;
                    stk_cnt++;
                end
            end
            FN_ROLL: begin
                if (opnd[31]) begin
                    stk_clear();
                    r.status = STS_NEGIDX;
                end else if (stk_cnt == 0 || opnd == 0) begin
                    // nothing moves
                end else if (opnd < stk_cnt) begin
                    k = stk_cnt - 1 - opnd;
                    saved = stk_mem[k];
                    for (int unsigned i = k; i + 1 < stk_cnt; i++) stk_mem[i] = stk_mem[i+1];
                    stk_mem[stk_cnt-1] = saved;
                end else begin
                    for (int unsigned i = 0; i + 1 < stk_cnt; i++) stk_mem[i] = stk_mem[i+1];
                    stk_mem[stk_cnt-1] = 32'd0;
                end
            end
            FN_CLEAR: stk_clear();
            default: ;
        endcase
        r.depth = stk_cnt[6:0];
        r.top_value = stk_cnt ? stk_mem[stk_cnt-1] : 32'd0;
        return r;
    endfunction

    // offer one request, hold it until accepted
    task automatic send_req(logic [3:0] fn, logic [31:0] opnd);
        in_t  req;
        out_t exp_item;
        req.func = fn;
        req.operand = opnd;
        while (!tx_calm && $urandom_range(99) < 21) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        exp_item = stack_predict(req);
        pending_results.insert(pending_results.size(), exp_item);
    endtask

    // drive ready at random, with an optional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else m_ready <= rx_calm || ($urandom_range(99) >= 21);
    end

    // compare each result with the oldest prediction
    always @(posedge aclk) begin
        out_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", m_data);
            end else begin
                exp_r = pending_results.pop_front();
                if (m_data !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_r, m_data);
                end
            end
        end
    end

    function automatic logic [31:0] rand_val();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_idx();
        case ($urandom_range(19))
            0: return $urandom | 32'h8000_0000;
            1: return $urandom_range(200, 64);
            2: return $urandom & 32'h7FFF_FFFF;
            default: return $urandom_range(stk_cnt + 1);
        endcase
    endfunction

    task automatic test_directed();
        send_req(FN_DOT, 0);
        send_req(FN_ADD, 0);
        send_req(FN_ROLL, 3);
        send_req(FN_PUSH, 32'h8000_0000);
        send_req(FN_DIV, 0);
        send_req(FN_PUSH, 32'd7);
        send_req(FN_SUB, 0);
        send_req(FN_PUSH, 32'h8000_0000);
        send_req(FN_PUSH, 32'hFFFF_FFFF);
        send_req(FN_DIV, 0);
        send_req(FN_PUSH, 32'h8000_0000);
        send_req(FN_PUSH, 32'hFFFF_FFFF);
        send_req(FN_MOD, 0);
        send_req(FN_PUSH, 32'h7FFF_FFFF);
        send_req(FN_PUSH, -32'sd3);
        send_req(FN_MUL, 0);
        send_req(FN_PICK, 40);
        send_req(FN_ROLL, 1);
        send_req(FN_ROLL, 99);
        send_req(FN_ROLL, 0);
        send_req(FN_PICK, 32'hFFFF_FFFF);
        send_req(FN_PUSH, 5);
        send_req(FN_ROLL, 32'h8000_0000);
        send_req(4'hF, 32'h1234_5678);
        send_req(FN_CLEAR, 0);
    endtask

    // fill the stack past full, starting with a long receiver hold-off
    task automatic test_overflow();
        rx_hold = 300;
        for (int i = 0; i < DEPTH + 3; i++) send_req(FN_PUSH, $urandom);
        send_req(FN_PICK, 2);
        send_req(FN_ROLL, DEPTH - 1);
        send_req(FN_ROLL, DEPTH + 5);
        send_req(FN_CLEAR, 0);
    endtask

    task automatic test_random(int n);
        int pick;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) tx_calm = 1'b1;
            if (i == n / 2 + 200) tx_calm = 1'b0;
            pick = $urandom_range(99);
            if (pick < 35) send_req(FN_PUSH, rand_val());
            else if (pick < 60) send_req(4'($urandom_range(FN_MOD, FN_ADD)), 0);
            else if (pick < 70) send_req(FN_DOT, $urandom);
            else if (pick < 80) send_req(FN_PICK, rand_idx());
            else if (pick < 92) send_req(FN_ROLL, rand_idx());
            else if (pick < 96) send_req(FN_CLEAR, $urandom);
            else send_req(4'($urandom_range(15, 10)), $urandom);
        end
        tx_calm = 1'b0;
    endtask

    initial begin
        stk_clear();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_overflow();
        rx_calm = 1'b1;
        test_random(200);
        rx_calm = 1'b0;
        test_random(1500);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
